// ===== rtl/rrq_pkg.sv =====
// Shared types, request and status codes for the round-robin run queue.
package rrq_pkg;

    localparam int RRQ_DEPTH_DEFAULT = 16;
    localparam int ID_W              = 16;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_NEXT   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FROZEN    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;

    // per-cell operations broadcast along the row
    localparam logic [2:0] OP_HOLD       = 3'd0;
    localparam logic [2:0] OP_SHIFT_IN   = 3'd1;
    localparam logic [2:0] OP_MOVE_FRONT = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_ROTATE     = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
        logic            occ;
    } cell_link_t;

    typedef struct packed {
        logic [2:0]      op;
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
    } cell_cmd_t;

endpackage

// ===== rtl/rrq_cell.sv =====
// One queue slot: holds an identity, compares it and moves it to or from its neighbours.
module rrq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rrq_pkg::cell_cmd_t cmd,
    input  rrq_pkg::cell_link_t left,
    input  rrq_pkg::cell_link_t right,
    input  rrq_pkg::cell_link_t head,
    input  logic               seen_in,
    output rrq_pkg::cell_link_t self,
    output logic               seen_out
);
    import rrq_pkg::*;

    logic [ID_W-1:0] tid_reg, tid_next;
    logic [ID_W-1:0] pid_reg, pid_next;
    logic            occ_reg, occ_next;
    logic            match;

    assign match    = occ_reg && (tid_reg == cmd.tid) && (pid_reg == cmd.pid);
    assign seen_out = seen_in | match;

    assign self.tid = tid_reg;
    assign self.pid = pid_reg;
    assign self.occ = occ_reg;

    always_comb
    begin
        tid_next = tid_reg;
        pid_next = pid_reg;
        occ_next = occ_reg;
        case (cmd.op)
            OP_SHIFT_IN:
            begin
                tid_next = left.tid;
                pid_next = left.pid;
                occ_next = left.occ;
            end
            OP_MOVE_FRONT:
            begin
                // slots up to and including the old position take the left word
                if (!seen_in)
                begin
                    tid_next = left.tid;
                    pid_next = left.pid;
                end
            end
            OP_DELETE:
            begin
                if (seen_out)
                begin
                    tid_next = right.tid;
                    pid_next = right.pid;
                    occ_next = right.occ;
                end
            end
            OP_ROTATE:
            begin
                if (right.occ)
                begin
                    tid_next = right.tid;
                    pid_next = right.pid;
                end
                else if (occ_reg)
                begin
                    // last occupied slot receives the old head
                    tid_next = head.tid;
                    pid_next = head.pid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
        pid_reg <= pid_next;
    end

endmodule

// ===== rtl/round_robin_run_queue.sv =====
// The result word of an accepted request is registered in the output register.
// Throughput: one request per cycle unless the output stalls; every slot updates in parallel.
// The match search ripples through the row of slots, so the row length sets the clock path.
// Reset: asynchronous, active low; empties the queue and clears the output valid.
// Slot contents are not reset; only the occupied flags are.
module round_robin_run_queue #(
    parameter int QUEUE_DEPTH = rrq_pkg::RRQ_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic [rrq_pkg::ID_W-1:0] thread_id,
    input  logic [rrq_pkg::ID_W-1:0] process_id,
    input  logic                     instant,
    input  logic                     thawed,
    input  logic                     frozen,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic                     has_thread,
    output logic [rrq_pkg::ID_W-1:0] out_thread_id,
    output logic [rrq_pkg::ID_W-1:0] out_process_id
);
    import rrq_pkg::*;

    cell_link_t      slot  [QUEUE_DEPTH];
    cell_link_t      left  [QUEUE_DEPTH];
    cell_link_t      right [QUEUE_DEPTH];
    logic            seen  [QUEUE_DEPTH+1];
    cell_cmd_t       cmd;
    logic            accept;
    logic            found;
    logic            full;
    logic            empty;

    logic            out_valid_reg, out_valid_next;
    logic [2:0]      status_reg, status_next;
    logic            has_reg, has_next;
    logic [ID_W-1:0] otid_reg, otid_next;
    logic [ID_W-1:0] opid_reg, opid_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign seen[0]  = 1'b0;
    assign found    = seen[QUEUE_DEPTH];
    assign full     = slot[QUEUE_DEPTH-1].occ;
    assign empty    = !slot[0].occ;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left[gi] = '{tid: thread_id, pid: process_id, occ: 1'b1};
            end
            else
            begin : g_mid_l
                assign left[gi] = slot[gi-1];
            end
            if (gi == QUEUE_DEPTH-1)
            begin : g_last
                assign right[gi] = '0;
            end
            else
            begin : g_mid_r
                assign right[gi] = slot[gi+1];
            end

            rrq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .left     (left[gi]),
                .right    (right[gi]),
                .head     (slot[0]),
                .seen_in  (seen[gi]),
                .self     (slot[gi]),
                .seen_out (seen[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        cmd.op          = OP_HOLD;
        cmd.tid         = thread_id;
        cmd.pid         = process_id;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        has_next        = has_reg;
        otid_next       = otid_reg;
        opid_next       = opid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            has_next       = 1'b0;
            otid_next      = '0;
            opid_next      = '0;
            case (req_type)
                REQ_ADD:
                begin
                    if (frozen)
                        status_next = ST_FROZEN;
                    else if (found && instant && !thawed)
                        cmd.op = OP_MOVE_FRONT;
                    else if (found)
                        status_next = ST_DUPLICATE;
                    else if (full)
                        status_next = ST_FULL;
                    else
                        cmd.op = OP_SHIFT_IN;
                end
                REQ_REMOVE:
                begin
                    if (found)
                        cmd.op = OP_DELETE;
                    else
                        status_next = ST_NOT_FOUND;
                end
                REQ_NEXT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cmd.op    = OP_ROTATE;
                        has_next  = 1'b1;
                        otid_next = slot[0].tid;
                        opid_next = slot[0].pid;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        has_reg    <= has_next;
        otid_reg   <= otid_next;
        opid_reg   <= opid_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign has_thread     = has_reg;
    assign out_thread_id  = otid_reg;
    assign out_process_id = opid_reg;

endmodule

// ===== rtl/rrq_checker.sv =====
// Port-level checks for the run queue, bound to the top level.
module rrq_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [1:0]               req_type,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [2:0]               status,
    input logic                     has_thread,
    input logic [rrq_pkg::ID_W-1:0] out_thread_id,
    input logic [rrq_pkg::ID_W-1:0] out_process_id
);
    import rrq_pkg::*;

    // a waiting result word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(has_thread)
            && $stable(out_thread_id) && $stable(out_process_id))
        else $error("result word changed while stalled");

    a_has_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_thread |-> status == ST_OK)
        else $error("thread returned with non-ok status");

    a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_NEXT |=>
            out_valid && (has_thread || status == ST_EMPTY))
        else $error("next gave neither a thread nor empty");

    a_other_no_thread: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type != REQ_NEXT |=>
            out_valid && !has_thread && out_thread_id == '0 && out_process_id == '0)
        else $error("thread returned for a non-next request");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while result word stalled");

endmodule

bind round_robin_run_queue rrq_checker u_rrq_checker (.*);

// ===== tb/round_robin_run_queue_tb.sv =====
// Self-checking testbench for the round-robin run queue: directed and random requests.
module round_robin_run_queue_tb;
    import rrq_pkg::*;

    localparam int         RUN_DEPTH    = RRQ_DEPTH_DEFAULT;
    localparam int         POOL_N       = 24;
    localparam int         RANDOM_ITEMS = 950;
    localparam int         LIMIT_CYCLES = 200000;
    localparam logic [1:0] REQ_BAD      = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] tid;
    } ident_t;

    typedef struct packed {
        logic [2:0]      st;
        logic            has;
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
    } run_result_t;

    class run_queue_scoreboard;
        ident_t      run_q[$];
        run_result_t awaited[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        // Predict the result word of an accepted request and update the queue copy.
        function void note_request(logic [1:0] req, ident_t who, logic inst, logic thaw,
                                   logic frz);
            run_result_t r;
            ident_t      head;
            int          pos;
            r   = '0;
            pos = -1;
            foreach (run_q[i])
                if (run_q[i] == who)
                    pos = i;
            case (req)
                REQ_ADD:
                begin
                    if (frz)
                        r.st = ST_FROZEN;
                    else
                    begin
                        if (inst && !thaw && pos >= 0)
                        begin
                            run_q.delete(pos);
                            pos = -1;
                        end
                        if (pos >= 0)
                            r.st = ST_DUPLICATE;
                        else if (run_q.size() >= RUN_DEPTH)
                            r.st = ST_FULL;
                        else
                        begin
                            run_q.push_front(who);
                            r.st = ST_OK;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (pos >= 0)
                    begin
                        run_q.delete(pos);
                        r.st = ST_OK;
                    end
                    else
                        r.st = ST_NOT_FOUND;
                end
                REQ_NEXT:
                begin
                    if (run_q.size() == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        head = run_q.pop_front();
                        run_q.push_back(head);
                        r.st  = ST_OK;
                        r.has = 1'b1;
                        r.tid = head.tid;
                        r.pid = head.pid;
                    end
                end
                default:
                    r.st = ST_OK;
            endcase
            awaited.push_back(r);
        endfunction

        task check_result(run_result_t got);
            run_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result word with nothing outstanding: %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.st !== want.st)
                report($sformatf("status got %0d want %0d", got.st, want.st));
            if (got.has !== want.has)
                report($sformatf("has_thread got %0b want %0b", got.has, want.has));
            if (got.tid !== want.tid)
                report($sformatf("out_thread_id got %h want %h", got.tid, want.tid));
            if (got.pid !== want.pid)
                report($sformatf("out_process_id got %h want %h", got.pid, want.pid));
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [1:0]      req_type;
    logic [ID_W-1:0] thread_id;
    logic [ID_W-1:0] process_id;
    logic            instant;
    logic            thawed;
    logic            frozen;
    logic            out_valid;
    logic            out_ready;
    logic [2:0]      status;
    logic            has_thread;
    logic [ID_W-1:0] out_thread_id;
    logic [ID_W-1:0] out_process_id;

    run_queue_scoreboard sb;
    bit                  idle_on;
    int                  cycles;
    ident_t              pool[POOL_N];

    round_robin_run_queue u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL round_robin_run_queue");
        $finish;
    end

    function automatic bit take_gap();
        return idle_on && ($urandom_range(99) < 19);
    endfunction

    // Present one request word and hold it until the queue takes it.
    task automatic send_request(input logic [1:0] req, input logic [ID_W-1:0] pid,
                                input logic [ID_W-1:0] tid, input logic inst,
                                input logic thaw, input logic frz);
        @(negedge clk);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        process_id <= pid;
        thread_id  <= tid;
        instant    <= inst;
        thawed     <= thaw;
        frozen     <= frz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req, '{pid: pid, tid: tid}, inst, thaw, frz);
    endtask

    // Result side: random back-pressure, check every accepted word.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            out_ready <= !take_gap();
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result('{st: status, has: has_thread, tid: out_thread_id,
                                  pid: out_process_id});
        end
    end

    initial
    begin
        int         n;
        int         roll;
        int         add_pct;
        int         rem_pct;
        logic [1:0] req;
        ident_t     who;

        sb         = new();
        idle_on    = 1'b1;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        req_type   = REQ_ADD;
        thread_id  = '0;
        process_id = '0;
        instant    = 1'b0;
        thawed     = 1'b0;
        frozen     = 1'b0;

        // corner identities first; later ones share a thread id with an earlier pid
        pool[0] = '{pid: 16'h0000, tid: 16'h0000};
        pool[1] = '{pid: 16'hFFFF, tid: 16'hFFFF};
        pool[2] = '{pid: 16'h0000, tid: 16'hFFFF};
        pool[3] = '{pid: 16'hFFFF, tid: 16'h0000};
        for (int i = 4; i < POOL_N; i++)
            if (i >= 12)
                pool[i] = '{pid: ID_W'($urandom), tid: pool[i-8].tid};
            else
                pool[i] = ident_t'($urandom);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, misses, refusals, move to front, rotation
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_ADD,    16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_request(REQ_ADD,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_ADD,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_request(REQ_ADD,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_ADD,    16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_request(REQ_ADD,    16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        send_request(REQ_ADD,    16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_NEXT,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(REQ_BAD,    16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_request(REQ_REMOVE, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);

        // random: phases swing between filling and draining so full and empty both occur
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = !(n >= 350 && n < 520);
            case ((n / 120) % 3)
                0:       begin add_pct = 60; rem_pct = 20; end
                1:       begin add_pct = 35; rem_pct = 35; end
                default: begin add_pct = 20; rem_pct = 50; end
            endcase
            roll = $urandom_range(99);
            if (roll < add_pct)
                req = REQ_ADD;
            else if (roll < add_pct + rem_pct)
                req = REQ_REMOVE;
            else if (roll < 95)
                req = REQ_NEXT;
            else
                req = REQ_BAD;
            if ($urandom_range(9) == 0)
                who = ident_t'($urandom);
            else
                who = pool[$urandom_range(POOL_N - 1)];
            send_request(req, who.pid, who.tid, 1'($urandom_range(1)),
                         1'($urandom_range(3) == 0), 1'($urandom_range(7) == 0));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        idle_on = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS round_robin_run_queue");
        else
            $display("FAIL round_robin_run_queue");
        $finish;
    end

endmodule
